### sv/bsp_pkg.sv
// Shared types and constants for the byte range to sector splitter.
`timescale 1ns / 1ps
package bsp_pkg;

  localparam int SECTOR_BYTES = 512;
  localparam int SECT_SHIFT   = $clog2(SECTOR_BYTES);
  localparam int OFF_W        = 32;
  localparam int CAP48_W      = 48;
  localparam int CAP28_W      = 28;
  localparam int MAXOFF_W     = CAP48_W + SECT_SHIFT;
  localparam int LBA_W        = 23;
  localparam int START_W      = 9;
  localparam int LEN_W        = 10;
  localparam int BUFPOS_W     = 15;
  localparam int CSIZE_W      = 16;
  localparam int CNT_W        = 7;

  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = CAP48_W;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP48 = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP28 = 1'b1;

  localparam logic [2:0] OP_NONE       = 3'd0;
  localparam logic [2:0] OP_FULL_READ  = 3'd1;
  localparam logic [2:0] OP_PART_READ  = 3'd2;
  localparam logic [2:0] OP_FULL_WRITE = 3'd3;
  localparam logic [2:0] OP_RMW        = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BEYOND   = 2'd1;
  localparam logic [1:0] ST_SPAN_BIG = 2'd2;

  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [OFF_W-1:0]  byte_offset;
    logic [OFF_W-1:0]  byte_count;
  } bsp_in_t;

  typedef struct packed {
    logic [2:0]          op_kind;
    logic [LBA_W-1:0]    sector_lba;
    logic [START_W-1:0]  start_in_sector;
    logic [LEN_W-1:0]    length_in_sector;
    logic [BUFPOS_W-1:0] buffer_position;
    logic [CSIZE_W-1:0]  clamped_size;
    logic [1:0]          status;
    logic                last_piece;
  } bsp_out_t;

  // One classified request, handed from front to back.
  typedef struct packed {
    logic                none;
    logic [1:0]          status;
    logic                cmd;
    logic [LBA_W-1:0]    first_lba;
    logic [START_W-1:0]  first_start;
    logic [LEN_W-1:0]    last_stop;
    logic [CNT_W-1:0]    count;
    logic [CSIZE_W-1:0]  csize;
  } bsp_desc_t;

endpackage

### sv/bsp_queue.sv
// Short descriptor queue between the front and back parts.
`timescale 1ns / 1ps
module bsp_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  bsp_pkg::bsp_desc_t push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output bsp_pkg::bsp_desc_t pop_data
);
  import bsp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  bsp_desc_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] fill_r, fill_nxt;
  logic do_push, do_pop;

  assign push_ready = (fill_r != CNT_QW'(DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### sv/bsp_front.sv
// Front part: capacity registers, request clamping and classification.
`timescale 1ns / 1ps
module bsp_front #(
  parameter int MAX_SPAN_SECTORS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bsp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bsp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bsp_pkg::bsp_in_t                    in_data,
  output logic                                push_valid,
  input  logic                                push_ready,
  output bsp_pkg::bsp_desc_t                  push_data
);
  import bsp_pkg::*;

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_CHK   = 3'd1;
  localparam logic [2:0] F_CLAMP = 3'd2;
  localparam logic [2:0] F_SPAN  = 3'd3;
  localparam logic [2:0] F_PUSH  = 3'd4;
  localparam int SPAN_W = LBA_W + 2;

  logic [2:0]           state_r, state_nxt;
  logic [CAP48_W-1:0]   cap48_r;
  logic [CAP28_W-1:0]   cap28_r;
  logic [CAP48_W-1:0]   cap_eff;
  logic [MAXOFF_W-1:0]  max_off;

  logic                 cmd_r;
  logic [OFF_W-1:0]     off_r;
  logic [OFF_W-1:0]     size_r;
  logic [OFF_W:0]       end_r;
  logic                 beyond_r;
  logic [OFF_W-1:0]     csize_r;
  logic [OFF_W:0]       lastb_r;

  logic [LBA_W-1:0]     first_lba;
  logic [LBA_W:0]       last_lba;
  logic [SPAN_W-1:0]    span;
  logic                 too_long;
  bsp_desc_t            desc;

  assign cap_eff  = (cap48_r != '0) ? cap48_r : CAP48_W'(cap28_r);
  assign max_off  = {cap_eff, {SECT_SHIFT{1'b0}}};
  assign in_ready = (state_r == F_IDLE);

  assign first_lba = off_r[OFF_W-1:SECT_SHIFT];
  assign last_lba  = lastb_r[OFF_W:SECT_SHIFT];
  assign span      = SPAN_W'(last_lba) - SPAN_W'(first_lba) + SPAN_W'(1);
  assign too_long  = (span > SPAN_W'(MAX_SPAN_SECTORS));

  always_comb begin
    desc             = '0;
    desc.none        = 1'b1;
    desc.status      = ST_OK;
    if (beyond_r) begin
      desc.status = ST_BEYOND;
    end else if (csize_r == '0) begin
      desc.status = ST_OK;
    end else if (too_long) begin
      desc.status = ST_SPAN_BIG;
    end else begin
      desc.none        = 1'b0;
      desc.cmd         = cmd_r;
      desc.first_lba   = first_lba;
      desc.first_start = off_r[START_W-1:0];
      desc.last_stop   = LEN_W'(lastb_r[SECT_SHIFT-1:0]) + LEN_W'(1);
      desc.count       = span[CNT_W-1:0];
      desc.csize       = csize_r[CSIZE_W-1:0];
    end
  end

  assign push_valid = (state_r == F_PUSH);
  assign push_data  = desc;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (in_valid) state_nxt = F_CHK;
      F_CHK:   state_nxt = F_CLAMP;
      F_CLAMP: state_nxt = F_SPAN;
      F_SPAN:  state_nxt = F_PUSH;
      F_PUSH:  if (push_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cap48_r <= '0;
      cap28_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_CAP48: cap48_r <= cfg_wdata[CAP48_W-1:0];
          CFG_CAP28: cap28_r <= cfg_wdata[CAP28_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          cmd_r  <= in_data.cmd;
          off_r  <= in_data.byte_offset;
          size_r <= in_data.byte_count;
        end
      end
      F_CHK: begin
        end_r    <= {1'b0, off_r} + {1'b0, size_r};
        beyond_r <= (MAXOFF_W'(off_r) > max_off);
      end
      F_CLAMP: begin
        if (MAXOFF_W'(end_r) > max_off) begin
          end_r <= max_off[OFF_W:0];
        end
      end
      F_SPAN: begin
        csize_r <= OFF_W'(end_r - {1'b0, off_r});
        lastb_r <= end_r - (OFF_W + 1)'(1);
      end
      default: ;
    endcase
  end

endmodule

### sv/bsp_back.sv
// Back part: walks one descriptor, one sector transfer per cycle unless out_ready stalls it.
`timescale 1ns / 1ps
module bsp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  bsp_pkg::bsp_desc_t pop_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bsp_pkg::bsp_out_t  out_data
);
  import bsp_pkg::*;

  logic                act_r, act_nxt;
  logic                out_valid_r, out_valid_nxt;
  bsp_out_t            out_r;
  logic                none_r;
  logic [1:0]          status_r;
  logic                cmd_r;
  logic [LBA_W-1:0]    lba_r;
  logic                first_r;
  logic [START_W-1:0]  start_r;
  logic [LEN_W-1:0]    stop_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [BUFPOS_W-1:0] pos_r;
  logic [CSIZE_W-1:0]  csize_r;

  logic                slot_free;
  logic                emit;
  logic                is_last;
  logic [START_W-1:0]  p_start;
  logic [LEN_W-1:0]    p_stop;
  logic [LEN_W-1:0]    p_len;
  logic                partial;
  bsp_out_t            piece;

  assign slot_free = !out_valid_r || out_ready;
  assign emit      = act_r && slot_free;
  assign pop_ready = !act_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign is_last = none_r || (cnt_r == CNT_W'(1));
  assign p_start = first_r ? start_r : '0;
  assign p_stop  = (cnt_r == CNT_W'(1)) ? stop_r : LEN_W'(SECTOR_BYTES);
  assign p_len   = p_stop - LEN_W'(p_start);
  assign partial = (p_len != LEN_W'(SECTOR_BYTES));

  always_comb begin
    piece            = '0;
    piece.status     = status_r;
    piece.last_piece = 1'b1;
    piece.op_kind    = OP_NONE;
    if (!none_r) begin
      piece.op_kind = (cmd_r == CMD_WRITE) ? (partial ? OP_RMW : OP_FULL_WRITE)
                                           : (partial ? OP_PART_READ : OP_FULL_READ);
      piece.sector_lba       = lba_r;
      piece.start_in_sector  = p_start;
      piece.length_in_sector = p_len;
      piece.buffer_position  = pos_r;
      piece.clamped_size     = csize_r;
      piece.last_piece       = is_last;
    end
  end

  always_comb begin
    act_nxt       = act_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (!act_r) begin
      act_nxt = pop_valid;
    end else if (emit) begin
      out_valid_nxt = 1'b1;
      act_nxt       = !is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!act_r && pop_valid) begin
      none_r   <= pop_data.none;
      status_r <= pop_data.status;
      cmd_r    <= pop_data.cmd;
      lba_r    <= pop_data.first_lba;
      first_r  <= 1'b1;
      start_r  <= pop_data.first_start;
      stop_r   <= pop_data.last_stop;
      cnt_r    <= pop_data.count;
      pos_r    <= '0;
      csize_r  <= pop_data.csize;
    end else if (emit) begin
      out_r   <= piece;
      lba_r   <= lba_r + LBA_W'(1);
      first_r <= 1'b0;
      cnt_r   <= cnt_r - CNT_W'(1);
      pos_r   <= pos_r + BUFPOS_W'(p_len);
    end
  end

endmodule

### sv/byte_range_to_sector_splitter.sv
// Top level of the byte range to sector splitter.
`timescale 1ns / 1ps
// A request (read/write, byte offset, byte count) is clamped to the device
// capacity (capacity_lba48, or capacity_lba28 when that is zero; 512-byte
// sectors) and cut into one transfer per touched sector in ascending LBA
// order, the last flagged by last_piece. Empty requests, offsets past the
// capacity and spans over MAX_SPAN_SECTORS give one op_kind none transfer
// with the status set. The front part checks, clamps and sizes a request
// and then pushes it; a two-entry queue feeds the back part, which loads
// it and gives one sector transfer per cycle unless out_ready stalls it.
// The user writes the capacity registers via cfg_we/cfg_index only while
// idle; the block does not enforce this.
module byte_range_to_sector_splitter #(
  parameter int MAX_SPAN_SECTORS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bsp_pkg::bsp_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bsp_pkg::bsp_out_t              out_data
);
  import bsp_pkg::*;

  logic      push_valid, push_ready;
  bsp_desc_t push_data;
  logic      pop_valid, pop_ready;
  bsp_desc_t pop_data;

  bsp_front #(
    .MAX_SPAN_SECTORS(MAX_SPAN_SECTORS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  bsp_queue #(
    .DEPTH(2)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  bsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### sv/bsp_checker.sv
// Port-level checks for the sector splitter, bound to the top level.
`timescale 1ns / 1ps
module bsp_props (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           cfg_we,
  input logic [bsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [bsp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input logic                           in_valid,
  input logic                           in_ready,
  input bsp_pkg::bsp_in_t               in_data,
  input logic                           out_valid,
  input logic                           out_ready,
  input bsp_pkg::bsp_out_t              out_data
);
  import bsp_pkg::*;

  // stalled transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.op_kind == OP_NONE |-> out_data.last_piece)
    else $error("none result not last");

  a_status_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.op_kind == OP_NONE)
    else $error("error status on a sector transfer");

  a_piece_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.op_kind != OP_NONE |->
      out_data.length_in_sector != '0 &&
      ({2'b0, out_data.start_in_sector} + {1'b0, out_data.length_in_sector})
        <= 11'(SECTOR_BYTES))
    else $error("piece overruns its sector");

endmodule

bind byte_range_to_sector_splitter bsp_props u_bsp_props (.*);
